@@ hw/rtl/debounced_down_counter_7seg_scan_defines.svh @@
// Assertion macros for the counter and display scan block
`ifndef DEBOUNCED_DOWN_COUNTER_7SEG_SCAN_DEFINES_SVH
`define DEBOUNCED_DOWN_COUNTER_7SEG_SCAN_DEFINES_SVH

// same-cycle implication
`define DDC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define DDC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ hw/rtl/ddc7s_pkg.sv @@
package ddc7s_pkg;

   localparam int COUNT_W   = 20;
   localparam int DIGIT_W   = 6;
   localparam int SEG_W     = 7;
   localparam int BCD_W     = 4;

   localparam logic [COUNT_W-1:0] START_COUNT_RESET = 20'd50000;

   // floor(x / 10) = (x * 838861) >> 23 for any 20-bit x
   localparam logic [COUNT_W-1:0] RECIP_TEN = 20'd838861;
   localparam int                 RECIP_SHIFT = 23;

   typedef logic [SEG_W-1:0] seg_type;

   function automatic seg_type seg_code(input logic [BCD_W-1:0] digit);
      seg_type code;
      case (digit)
         4'd0:    code = 7'h3F;
         4'd1:    code = 7'h06;
         4'd2:    code = 7'h5B;
         4'd3:    code = 7'h4F;
         4'd4:    code = 7'h66;
         4'd5:    code = 7'h6D;
         4'd6:    code = 7'h7D;
         4'd7:    code = 7'h07;
         4'd8:    code = 7'h7F;
         4'd9:    code = 7'h6F;
         default: code = 7'h00;
      endcase
      return code;
   endfunction

endpackage

@@ hw/rtl/debounced_down_counter_7seg_scan.sv @@
// A result beat appears in the cycle after its request beat is accepted.
// Throughput: one request per cycle if no stall; the scan digit split (one 20x20
// reciprocal multiply) and the qualifier update sit between the state and result
// registers. Reset (synchronous, active high): count and scan snapshot take 50000,
// digit position, debounce state and qualifier clear, digits are driven off.
`include "debounced_down_counter_7seg_scan_defines.svh"

module debounced_down_counter_7seg_scan #(
   parameter int NUM_DIGITS     = 6,
   parameter int STABLE_SAMPLES = 5
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_opcode,
   input  logic                              req_button_pressed,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [ddc7s_pkg::DIGIT_W-1:0]     rsp_digit_select,
   output logic [ddc7s_pkg::SEG_W-1:0]       rsp_segments,
   output logic [ddc7s_pkg::COUNT_W-1:0]     rsp_count_value,
   output logic                              rsp_button_state,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ddc7s_pkg::COUNT_W-1:0]     csr_start_count
);
   import ddc7s_pkg::*;

   localparam int POS_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
   localparam int PROD_W = 2 * COUNT_W;
   localparam logic [DIGIT_W-1:0] DIGIT_MASK = DIGIT_W'((1 << NUM_DIGITS) - 1);

   logic                      rsp_valid_ff;
   logic [DIGIT_W-1:0]        rsp_digit_select_ff, rsp_digit_select_in;
   seg_type                   rsp_segments_ff, rsp_segments_in;
   logic [COUNT_W-1:0]        rsp_count_value_ff;

   logic [COUNT_W-1:0]        count_ff, count_in;
   logic [COUNT_W-1:0]        scan_value_ff, scan_value_in;
   logic [POS_W-1:0]          digit_pos_ff, digit_pos_in;
   logic                      debounced_ff, debounced_in;
   logic [STABLE_SAMPLES-1:0] sample_shift_ff, sample_shift_in;
   logic                      sampling_active_ff, sampling_active_in;

   logic                      req_accept;
   logic                      csr_write;
   logic [PROD_W-1:0]         recip_prod;
   logic [COUNT_W-1:0]        scan_quot;
   logic [COUNT_W-1:0]        scan_rem_full;
   logic [POS_W:0]            pos_inc;
   logic                      mismatch;
   logic                      armed;
   logic [STABLE_SAMPLES-1:0] shift_next;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign csr_write  = csr_valid && csr_ready;
   assign csr_ready  = 1'b1;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_digit_select = rsp_digit_select_ff;
   assign rsp_segments     = rsp_segments_ff;
   assign rsp_count_value  = rsp_count_value_ff;
   assign rsp_button_state = debounced_ff;

   assign recip_prod    = PROD_W'(scan_value_ff) * PROD_W'(RECIP_TEN);
   assign scan_quot     = COUNT_W'(recip_prod >> RECIP_SHIFT);
   assign scan_rem_full = scan_value_ff - ((scan_quot << 3) + (scan_quot << 1));
   assign pos_inc       = (POS_W+1)'(digit_pos_ff) + (POS_W+1)'(1);

   assign mismatch   = debounced_ff ^ req_button_pressed;
   assign armed      = sampling_active_ff || mismatch;
   assign shift_next = {sample_shift_ff[STABLE_SAMPLES-2:0], mismatch};

   always_comb begin
      rsp_digit_select_in = rsp_digit_select_ff;
      rsp_segments_in     = rsp_segments_ff;
      scan_value_in       = scan_value_ff;
      digit_pos_in        = digit_pos_ff;
      count_in            = count_ff;
      debounced_in        = debounced_ff;
      sample_shift_in     = sample_shift_ff;
      sampling_active_in  = armed;

      if (!req_opcode) begin
         rsp_digit_select_in = ~(DIGIT_W'(1) << digit_pos_ff) & DIGIT_MASK;
         rsp_segments_in     = seg_code(scan_rem_full[BCD_W-1:0]);
         if (pos_inc == (POS_W+1)'(NUM_DIGITS)) begin
            digit_pos_in  = '0;
            scan_value_in = count_ff;
         end else begin
            digit_pos_in  = pos_inc[POS_W-1:0];
            scan_value_in = scan_quot;
         end
      end else if (armed) begin
         sample_shift_in = shift_next;
         if (&shift_next) begin
            debounced_in       = !debounced_ff;
            sampling_active_in = 1'b0;
            sample_shift_in    = '0;
            if (debounced_ff && (count_ff != '0)) begin
               count_in = count_ff - COUNT_W'(1);
            end
         end else if (shift_next == '0) begin
            sampling_active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff        <= 1'b0;
         rsp_digit_select_ff <= '1;
         rsp_segments_ff     <= '0;
         count_ff            <= START_COUNT_RESET;
         scan_value_ff       <= START_COUNT_RESET;
         digit_pos_ff        <= '0;
         debounced_ff        <= 1'b0;
         sample_shift_ff     <= '0;
         sampling_active_ff  <= 1'b0;
      end else begin
         if (req_accept) begin
            rsp_valid_ff        <= 1'b1;
            rsp_digit_select_ff <= rsp_digit_select_in;
            rsp_segments_ff     <= rsp_segments_in;
            count_ff            <= count_in;
            scan_value_ff       <= scan_value_in;
            digit_pos_ff        <= digit_pos_in;
            debounced_ff        <= debounced_in;
            sample_shift_ff     <= sample_shift_in;
            sampling_active_ff  <= sampling_active_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_write) begin
            count_ff      <= csr_start_count;
            scan_value_ff <= csr_start_count;
            digit_pos_ff  <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_count_value_ff <= count_in;
      end
   end

   `DDC_ASSERT_NEXT(a_rsp_after_accept, clock, reset, req_accept, rsp_valid_ff)
   `DDC_ASSERT_NOW(a_pos_in_range, clock, reset, 1'b1, digit_pos_ff < NUM_DIGITS)
   `DDC_ASSERT_NOW(a_one_digit_on, clock, reset, 1'b1, $countones(~rsp_digit_select_ff & DIGIT_MASK) <= 1)
   `DDC_ASSERT_NOW(a_shift_needs_arm, clock, reset, sample_shift_ff != '0, sampling_active_ff)
   `DDC_ASSERT_NEXT(a_count_never_rises, clock, reset, !csr_write, count_ff <= $past(count_ff))

endmodule
